>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. All checks are clocked on i_clk and
// are held off while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/rast_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rast_pkg;

    localparam int LEAVES     = 1024;
    localparam int LOG_LEAVES = $clog2(LEAVES);
    localparam int NODES      = 2 * LEAVES;
    localparam int NODE_W     = LOG_LEAVES + 1;
    localparam int LVL_W      = $clog2(LOG_LEAVES + 1);

    localparam int IDX_W = 11;
    localparam int IN_W  = 32;
    localparam int VAL_W = 48;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-3:0] REG_LEAF_COUNT   = '0;
    localparam logic [IDX_W-1:0]  LEAF_COUNT_RESET = IDX_W'(LEAVES);

    typedef logic signed [VAL_W-1:0] t_val;

    localparam t_val VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_BUILD = 2'd1,
        OP_ADD   = 2'd2,
        OP_MAX   = 2'd3
    } t_op;

    // Signed add clamped to the 48-bit range.
    function automatic t_val sat_add(input t_val a, input t_val b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/rast_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one word per operation.
interface rast_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [rast_pkg::IDX_W-1:0]    first_index;
    logic [rast_pkg::IDX_W-1:0]    last_index;
    logic signed [rast_pkg::IN_W-1:0] value;

    modport source (output valid, output operation, output first_index,
                    output last_index, output value, input ready);
    modport sink   (input valid, input operation, input first_index,
                    input last_index, input value, output ready);
endinterface

// Result channel: one word per range max.
interface rast_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rast_pkg::VAL_W-1:0] max_value;
    logic                              range_empty;

    modport source (output valid, output max_value, output range_empty, input ready);
    modport sink   (input valid, input max_value, input range_empty, output ready);
endinterface

`default_nettype wire

>>> rtl/range_add_max_segment_tree.sv
// Lazy segment tree over leaf positions 1..1024 with range add and range max.
// Operation 0 writes one base value into the leaf store, 1 builds the max
// tree from the store and clears every pending add, 2 adds a signed amount
// to every leaf in first..last, and 3 returns the maximum over first..last
// as one output word. Node maxima and pending adds saturate to the signed
// 48-bit range after every addition. The range is clipped to leaf_count; an
// empty range yields the most negative value with range_empty set. Timing is
// set by the single read port of each node memory: every visited node is
// read, settled and written back, a node that pushes its pending add to both
// children reads and rewrites each child's add in turn, and a range add pulls
// a new maximum up by reading both children of each parent. A range operation
// visits up to about four nodes per level over eleven levels; when the range
// covers every leaf only the root is visited. A build reads each leaf from the
// store and both children of each inner node. After reset a clearing pass over
// every node address zeroes the memories; no word is accepted until it ends,
// while configuration writes are taken at any time. The result register lets
// the next word enter while a result still waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module range_add_max_segment_tree (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rast_in_if.sink                            i_in,
    rast_out_if.source                         o_out,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [rast_pkg::APB_AW-1:0]   i_paddr,
    input  wire logic [rast_pkg::APB_DW-1:0]   i_pwdata,
    output logic      [rast_pkg::APB_DW-1:0]   o_prdata,
    output logic                               o_pready
);

    localparam int LOG  = rast_pkg::LOG_LEAVES;
    localparam int NW   = rast_pkg::NODE_W;
    localparam int LW   = rast_pkg::LVL_W;
    localparam int IW   = rast_pkg::IDX_W;
    localparam int XW   = rast_pkg::IN_W;

    typedef enum logic [18:0] {
        ST_CLEAR  = 19'b0000000000000000001,
        ST_IDLE   = 19'b0000000000000000010,
        ST_OUT    = 19'b0000000000000000100,
        ST_BLD_RD = 19'b0000000000000001000,
        ST_BLD_R2 = 19'b0000000000000010000,
        ST_BLD_WR = 19'b0000000000000100000,
        ST_RD     = 19'b0000000000001000000,
        ST_SET    = 19'b0000000000010000000,
        ST_SAT1   = 19'b0000000000100000000,
        ST_SAT2   = 19'b0000000001000000000,
        ST_WN     = 19'b0000000010000000000,
        ST_CRD    = 19'b0000000100000000000,
        ST_CA1    = 19'b0000001000000000000,
        ST_CA2    = 19'b0000010000000000000,
        ST_DEC    = 19'b0000100000000000000,
        ST_UP     = 19'b0001000000000000000,
        ST_PRD    = 19'b0010000000000000000,
        ST_PR1    = 19'b0100000000000000000,
        ST_PR2    = 19'b1000000000000000000
    } t_state;

    // Configuration register.
    logic [IW-1:0] r_leaf_cnt;
    logic          cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_prdata = (i_paddr[rast_pkg::APB_AW-1:2] == rast_pkg::REG_LEAF_COUNT)
                      ? {{(rast_pkg::APB_DW-IW){1'b0}}, r_leaf_cnt} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_cnt <= rast_pkg::LEAF_COUNT_RESET;
        end else if (cfg_wr && i_paddr[rast_pkg::APB_AW-1:2] == rast_pkg::REG_LEAF_COUNT) begin
            r_leaf_cnt <= i_pwdata[IW-1:0];
        end
    end

    // Memories: node maxima, pending adds and the leaf store.
    rast_pkg::t_val nm_mem [rast_pkg::NODES];
    rast_pkg::t_val pd_mem [rast_pkg::NODES];
    logic signed [XW-1:0] base_mem [rast_pkg::LEAVES];

    logic           nm_we, pd_we, base_we;
    logic [NW-1:0]  nm_wa, nm_ra, pd_wa, pd_ra;
    logic [LOG-1:0] base_wa, base_ra;
    rast_pkg::t_val nm_wd, pd_wd, nm_rd, pd_rd;
    logic signed [XW-1:0] base_wd, base_rd;

    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            nm_mem[nm_wa] <= nm_wd;
        end
        nm_rd <= nm_mem[nm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pd_we) begin
            pd_mem[pd_wa] <= pd_wd;
        end
        pd_rd <= pd_mem[pd_ra];
    end

    always_ff @(posedge i_clk) begin
        if (base_we) begin
            base_mem[base_wa] <= base_wd;
        end
        base_rd <= base_mem[base_ra];
    end

    // Control and working registers.
    t_state         r_state, n_state;
    logic [NW-1:0]  r_node, n_node, r_child, n_child, r_clr, n_clr;
    logic [LW-1:0]  r_level, n_level;
    rast_pkg::t_op  r_op, n_op;
    logic [LOG-1:0] r_lo0, n_lo0, r_hi0, n_hi0;
    logic signed [XW-1:0] r_x, n_x;
    rast_pkg::t_val r_nm, n_nm, r_p, n_p, r_c, n_c, r_tmp, n_tmp, r_best, n_best;
    logic           r_push_p, n_push_p, r_push_x, n_push_x, r_empty, n_empty;
    logic           r_ovalid, n_ovalid;
    rast_pkg::t_val r_omax, n_omax;
    logic           r_oempty, n_oempty;

    // Span of the current node, as 0-based leaf positions.
    logic [LW-1:0]  sh;
    logic [NW-1:0]  node_sh;
    logic [LOG-1:0] a0, b0, span_mask;
    logic           is_leaf, full, disj;

    assign sh        = LW'(LOG) - r_level;
    assign node_sh   = r_node << sh;
    assign span_mask = ~({LOG{1'b1}} << sh);
    assign a0        = node_sh[LOG-1:0];
    assign b0        = a0 | span_mask;
    assign is_leaf   = (r_level == LW'(LOG));
    assign full      = (r_lo0 <= a0) && (b0 <= r_hi0);
    assign disj      = (r_hi0 < a0) || (b0 < r_lo0);

    // Request decode.
    logic          in_acc;
    logic [IW-1:0] cnt, lo, hi, lo_m1, hi_m1, first_m1;
    logic          rng_empty;
    rast_pkg::t_val x_ext;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign cnt        = (r_leaf_cnt > IW'(rast_pkg::LEAVES)) ? IW'(rast_pkg::LEAVES) : r_leaf_cnt;
    assign lo         = (i_in.first_index == '0) ? IW'(1) : i_in.first_index;
    assign hi         = (i_in.last_index > cnt) ? cnt : i_in.last_index;
    assign rng_empty  = (cnt == '0) || (lo > hi);
    assign lo_m1      = lo - IW'(1);
    assign hi_m1      = hi - IW'(1);
    assign first_m1   = i_in.first_index - IW'(1);
    assign x_ext      = {{(rast_pkg::VAL_W-XW){r_x[XW-1]}}, r_x};

    always_comb begin
        n_state  = r_state;
        n_node   = r_node;
        n_child  = r_child;
        n_clr    = r_clr;
        n_level  = r_level;
        n_op     = r_op;
        n_lo0    = r_lo0;
        n_hi0    = r_hi0;
        n_x      = r_x;
        n_nm     = r_nm;
        n_p      = r_p;
        n_c      = r_c;
        n_tmp    = r_tmp;
        n_best   = r_best;
        n_push_p = r_push_p;
        n_push_x = r_push_x;
        n_empty  = r_empty;
        n_ovalid = r_ovalid && !o_out.ready;
        n_omax   = r_omax;
        n_oempty = r_oempty;
        nm_we    = 1'b0;
        nm_wa    = r_node;
        nm_wd    = '0;
        nm_ra    = r_node;
        pd_we    = 1'b0;
        pd_wa    = r_node;
        pd_wd    = '0;
        pd_ra    = r_node;
        base_we  = 1'b0;
        base_wa  = first_m1[LOG-1:0];
        base_wd  = i_in.value;
        base_ra  = r_node[LOG-1:0];

        case (r_state)
            ST_CLEAR: begin
                nm_we   = 1'b1;
                nm_wa   = r_clr;
                pd_we   = 1'b1;
                pd_wa   = r_clr;
                base_we = 1'b1;
                base_wa = r_clr[LOG-1:0];
                base_wd = '0;
                if (r_clr == NW'(rast_pkg::NODES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + NW'(1);
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_op = rast_pkg::t_op'(i_in.operation);
                    case (rast_pkg::t_op'(i_in.operation))
                        rast_pkg::OP_WRITE: begin
                            base_we = (i_in.first_index != '0) &&
                                      (i_in.first_index <= IW'(rast_pkg::LEAVES));
                        end
                        rast_pkg::OP_BUILD: begin
                            n_node  = NW'(rast_pkg::NODES - 1);
                            n_state = ST_BLD_RD;
                        end
                        rast_pkg::OP_ADD, rast_pkg::OP_MAX: begin
                            n_lo0   = lo_m1[LOG-1:0];
                            n_hi0   = hi_m1[LOG-1:0];
                            n_x     = i_in.value;
                            n_best  = rast_pkg::VAL_MIN;
                            n_node  = NW'(1);
                            n_level = '0;
                            n_empty = rng_empty;
                            if (!rng_empty) begin
                                n_state = ST_RD;
                            end else if (rast_pkg::t_op'(i_in.operation) == rast_pkg::OP_MAX) begin
                                n_state = ST_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_omax   = r_best;
                    n_oempty = r_empty;
                    n_state  = ST_IDLE;
                end
            end
            // Build runs bottom-up from the last node down to the root.
            ST_BLD_RD: begin
                nm_ra   = {r_node[NW-2:0], 1'b0};
                n_state = ST_BLD_R2;
            end
            ST_BLD_R2: begin
                if (r_node[NW-1]) begin
                    nm_we = 1'b1;
                    nm_wd = {{(rast_pkg::VAL_W-XW){base_rd[XW-1]}}, base_rd};
                    pd_we = 1'b1;
                    n_node  = r_node - NW'(1);
                    n_state = ST_BLD_RD;
                end else begin
                    n_tmp   = nm_rd;
                    nm_ra   = {r_node[NW-2:0], 1'b1};
                    n_state = ST_BLD_WR;
                end
            end
            ST_BLD_WR: begin
                nm_we = 1'b1;
                nm_wd = (r_tmp > nm_rd) ? r_tmp : nm_rd;
                pd_we = 1'b1;
                if (r_node == NW'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_node  = r_node - NW'(1);
                    n_state = ST_BLD_RD;
                end
            end
            // Visit of one node: settle its pending add, then the range test.
            ST_RD: begin
                n_state = ST_SET;
            end
            ST_SET: begin
                n_nm    = nm_rd;
                n_p     = pd_rd;
                n_state = ST_SAT1;
            end
            ST_SAT1: begin
                if (r_p != '0) begin
                    n_nm = rast_pkg::sat_add(r_nm, r_p);
                end
                n_push_p = (r_p != '0) && !is_leaf;
                n_push_x = (r_op == rast_pkg::OP_ADD) && full && (r_x != '0) && !is_leaf;
                n_state  = ST_SAT2;
            end
            ST_SAT2: begin
                if ((r_op == rast_pkg::OP_ADD) && full && (r_x != '0)) begin
                    n_nm = rast_pkg::sat_add(r_nm, x_ext);
                end
                n_state = ST_WN;
            end
            ST_WN: begin
                nm_we = 1'b1;
                nm_wd = r_nm;
                pd_we = 1'b1;
                if ((r_op == rast_pkg::OP_MAX) && full && (r_nm > r_best)) begin
                    n_best = r_nm;
                end
                if (r_push_p || r_push_x) begin
                    n_child = {r_node[NW-2:0], 1'b0};
                    n_state = ST_CRD;
                end else begin
                    n_state = ST_DEC;
                end
            end
            // Push the settled add and, on a covered add, the addend itself.
            ST_CRD: begin
                pd_ra   = r_child;
                n_state = ST_CA1;
            end
            ST_CA1: begin
                n_c     = r_push_p ? rast_pkg::sat_add(pd_rd, r_p) : pd_rd;
                n_state = ST_CA2;
            end
            ST_CA2: begin
                pd_we = 1'b1;
                pd_wa = r_child;
                pd_wd = r_push_x ? rast_pkg::sat_add(r_c, x_ext) : r_c;
                if (!r_child[0]) begin
                    n_child = r_child + NW'(1);
                    n_state = ST_CRD;
                end else begin
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                if (full || disj) begin
                    n_state = ST_UP;
                end else begin
                    n_node  = {r_node[NW-2:0], 1'b0};
                    n_level = r_level + LW'(1);
                    n_state = ST_RD;
                end
            end
            ST_UP: begin
                if (r_node == NW'(1)) begin
                    n_state = (r_op == rast_pkg::OP_MAX) ? ST_OUT : ST_IDLE;
                end else if (!r_node[0]) begin
                    n_node  = r_node + NW'(1);
                    n_state = ST_RD;
                end else begin
                    n_node  = r_node >> 1;
                    n_level = r_level - LW'(1);
                    n_state = (r_op == rast_pkg::OP_ADD) ? ST_PRD : ST_UP;
                end
            end
            // Pull the children's maxima up into the parent after a range add.
            ST_PRD: begin
                nm_ra   = {r_node[NW-2:0], 1'b0};
                n_state = ST_PR1;
            end
            ST_PR1: begin
                n_tmp   = nm_rd;
                nm_ra   = {r_node[NW-2:0], 1'b1};
                n_state = ST_PR2;
            end
            ST_PR2: begin
                nm_we   = 1'b1;
                nm_wd   = (r_tmp > nm_rd) ? r_tmp : nm_rd;
                n_state = ST_UP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_child  <= n_child;
        r_level  <= n_level;
        r_op     <= n_op;
        r_lo0    <= n_lo0;
        r_hi0    <= n_hi0;
        r_x      <= n_x;
        r_nm     <= n_nm;
        r_p      <= n_p;
        r_c      <= n_c;
        r_tmp    <= n_tmp;
        r_best   <= n_best;
        r_push_p <= n_push_p;
        r_push_x <= n_push_x;
        r_empty  <= n_empty;
        r_omax   <= n_omax;
        r_oempty <= n_oempty;
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.max_value   = r_omax;
    assign o_out.range_empty = r_oempty;

    // The level register always matches the depth of the node being read.
    `ASSERT_IMPL(a_level_match, r_state == ST_RD, (r_node >> r_level) == NW'(1))
    // Only inner nodes can straddle a range edge.
    `ASSERT_IMPL(a_partial_inner, (r_state == ST_DEC) && !full && !disj, !is_leaf)
    // A non-empty range max starts its walk at the root right away.
    `ASSERT_NEXT(a_query_walk,
        in_acc && (i_in.operation == rast_pkg::OP_MAX) && !rng_empty,
        (r_state == ST_RD) && (r_node == NW'(1)))

endmodule

`default_nettype wire
